>>> rtl/ctes_pkg.sv
// Shared constants and helpers for the civil time to epoch seconds converter.
package ctes_pkg;

  localparam int unsigned YearW   = 14;
  localparam int unsigned MonthW  = 4;
  localparam int unsigned DayW    = 5;
  localparam int unsigned HourW   = 5;
  localparam int unsigned MinuteW = 6;
  localparam int unsigned SecondW = 6;
  localparam int unsigned EpochW  = 38;

  localparam int unsigned DoyW  = 9;   // day of March-based year, up to 397
  localparam int unsigned TodW  = 17;  // seconds of day, up to 115443
  localparam int unsigned DaysW = 23;  // day count, up to about 6.0e6
  localparam int unsigned ProdW = DaysW + TodW;

  // floor(y / 100) = (y * 5243) >> 19 for every 14-bit y
  localparam int unsigned DivMulW   = 13;
  localparam int unsigned DivShift  = 19;
  localparam int unsigned DivProdW  = YearW + DivMulW;
  localparam int unsigned CentW     = DivProdW - DivShift;
  localparam logic [DivMulW-1:0] DivMul = 13'd5243;

  localparam logic [DaysW-1:0] DaysPerYear    = 23'd365;
  localparam logic [DaysW-1:0] EpochDayOffset = 23'd719468;
  localparam logic [TodW-1:0]  SecPerDay      = 17'd86400;
  localparam logic [TodW-1:0]  SecPerHour     = 17'd3600;
  localparam logic [TodW-1:0]  SecPerMinute   = 17'd60;
  localparam logic [EpochW-1:0] EpochMax      = {EpochW{1'b1}};

  // First day of each month in a year that starts in March: (153*m + 2) / 5
  function automatic logic [DoyW-1:0] month_start(input logic [MonthW-1:0] mshift);
    logic [DoyW-1:0] r;
    case (mshift)
      4'd0:    r = 9'd0;
      4'd1:    r = 9'd31;
      4'd2:    r = 9'd61;
      4'd3:    r = 9'd92;
      4'd4:    r = 9'd122;
      4'd5:    r = 9'd153;
      4'd6:    r = 9'd184;
      4'd7:    r = 9'd214;
      4'd8:    r = 9'd245;
      4'd9:    r = 9'd275;
      4'd10:   r = 9'd306;
      4'd11:   r = 9'd337;
      4'd12:   r = 9'd367;
      default: r = 9'd0;
    endcase
    return r;
  endfunction

endpackage

>>> rtl/ctes_days.sv
// Day count pipeline: three stages from a calendar date to days since the epoch.
module ctes_days import ctes_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               en_i,
  input  logic               valid_i,
  input  logic [YearW-1:0]   year_i,
  input  logic [MonthW-1:0]  month_i,
  input  logic [DayW-1:0]    day_i,
  input  logic [HourW-1:0]   hour_i,
  input  logic [MinuteW-1:0] minute_i,
  input  logic [SecondW-1:0] second_i,
  output logic               valid_o,
  output logic [DaysW-1:0]   days_o,
  output logic [TodW-1:0]    tod_o
);

  // stage 1: March-based year, day of year, seconds of day
  logic               v1_q, v1_d;
  logic [YearW-1:0]   y1_q, y1_d;
  logic               neg1_q, neg1_d;
  logic [DoyW-1:0]    doy1_q, doy1_d;
  logic [TodW-1:0]    tod1_q, tod1_d;

  logic [MonthW-1:0]  mon;
  logic [MonthW-1:0]  mshift;
  logic [DoyW-1:0]    dm1;
  logic               early;

  always_comb begin
    mon    = (month_i == '0) ? MonthW'(1) : month_i;
    dm1    = (day_i == '0) ? '0 : DoyW'(day_i - DayW'(1));
    early  = (mon <= MonthW'(2));
    mshift = early ? (mon + MonthW'(9)) : (mon - MonthW'(3));
    // January and February belong to the previous March-based year
    neg1_d = early && (year_i == '0);
    y1_d   = (early && (year_i != '0)) ? (year_i - YearW'(1)) : year_i;
    doy1_d = month_start(mshift) + dm1;
    tod1_d = TodW'(hour_i) * SecPerHour + TodW'(minute_i) * SecPerMinute
           + TodW'(second_i);
    v1_d   = valid_i;
  end

  // stage 2: whole years to days, 365*y + y/4 - y/100 + y/400
  logic               v2_q;
  logic [DaysW-1:0]   yd2_q, yd2_d;
  logic               neg2_q;
  logic [DoyW-1:0]    doy2_q;
  logic [TodW-1:0]    tod2_q;

  logic [DivProdW-1:0] div_prod;
  logic [CentW-1:0]    cent;

  always_comb begin
    div_prod = DivProdW'(y1_q) * DivProdW'(DivMul);
    cent     = div_prod[DivProdW-1:DivShift];
    yd2_d    = DaysW'(y1_q) * DaysPerYear + DaysW'(y1_q >> 2) - DaysW'(cent)
             + DaysW'(cent >> 2);
  end

  // stage 3: add day of year, shift to the epoch, clamp at zero
  logic               v3_q;
  logic [DaysW-1:0]   days3_q, days3_d;
  logic [TodW-1:0]    tod3_q;
  logic [DaysW-1:0]   day_sum;

  always_comb begin
    day_sum = yd2_q + DaysW'(doy2_q);
    if (neg2_q || (day_sum < EpochDayOffset)) begin
      days3_d = '0;
    end else begin
      days3_d = day_sum - EpochDayOffset;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
    end else if (en_i) begin
      v1_q <= v1_d;
      v2_q <= v1_q;
      v3_q <= v2_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      y1_q    <= y1_d;
      neg1_q  <= neg1_d;
      doy1_q  <= doy1_d;
      tod1_q  <= tod1_d;
      yd2_q   <= yd2_d;
      neg2_q  <= neg1_q;
      doy2_q  <= doy1_q;
      tod2_q  <= tod1_q;
      days3_q <= days3_d;
      tod3_q  <= tod2_q;
    end
  end

  assign valid_o = v3_q;
  assign days_o  = days3_q;
  assign tod_o   = tod3_q;

endmodule

>>> rtl/civil_time_to_epoch_seconds_top.sv
// Top level: calendar time in, seconds since 1970-01-01 out, five pipeline stages.
//
// Input channel in_valid_i / in_ready_o carries one calendar time word
// (year_i, month_i, day_i, hour_i, minute_i, second_i). Output channel
// out_valid_o / out_ready_i carries epoch_seconds_o.
// A zero month or day counts as one; dates before 1970 give zero days, with
// the time of day still added; results past 38 bits saturate to all ones.
//
// Throughput: one word per cycle while the receiver does not stall; the
// stages are: date decode, years to days, epoch shift and clamp,
// days times 86400, time-of-day add and saturate.
// Reset clears all stage valid bits; the pipeline comes up empty and ready.
// When the receiver stalls with a result waiting, every stage holds and
// in_ready_o drops; bubbles inside the pipeline are not squeezed out.
module civil_time_to_epoch_seconds_top import ctes_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  logic [YearW-1:0]   year_i,
  input  logic [MonthW-1:0]  month_i,
  input  logic [DayW-1:0]    day_i,
  input  logic [HourW-1:0]   hour_i,
  input  logic [MinuteW-1:0] minute_i,
  input  logic [SecondW-1:0] second_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output logic [EpochW-1:0]  epoch_seconds_o
);

  logic             adv;
  logic             days_valid;
  logic [DaysW-1:0] days;
  logic [TodW-1:0]  tod;

  // advance unless a finished word is held at the output
  assign adv        = !out_valid_o || out_ready_i;
  assign in_ready_o = adv;

  ctes_days u_days (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .en_i     (adv),
    .valid_i  (in_valid_i),
    .year_i   (year_i),
    .month_i  (month_i),
    .day_i    (day_i),
    .hour_i   (hour_i),
    .minute_i (minute_i),
    .second_i (second_i),
    .valid_o  (days_valid),
    .days_o   (days),
    .tod_o    (tod)
  );

  // stage 4: days to seconds
  logic             v4_q;
  logic [ProdW-1:0] prod4_q, prod4_d;
  logic [TodW-1:0]  tod4_q;

  assign prod4_d = ProdW'(days) * ProdW'(SecPerDay);

  // stage 5: add time of day, saturate
  logic              v5_q;
  logic [EpochW-1:0] sec5_q, sec5_d;
  logic [ProdW-1:0]  total;

  always_comb begin
    total = prod4_q + ProdW'(tod4_q);
    if (total[ProdW-1:EpochW] != '0) begin
      sec5_d = EpochMax;
    end else begin
      sec5_d = total[EpochW-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v4_q <= 1'b0;
      v5_q <= 1'b0;
    end else if (adv) begin
      v4_q <= days_valid;
      v5_q <= v4_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      prod4_q <= prod4_d;
      tod4_q  <= tod;
      sec5_q  <= sec5_d;
    end
  end

  assign out_valid_o     = v5_q;
  assign epoch_seconds_o = sec5_q;

  // a refused word means the output is held by the receiver
  a_refuse_only_on_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && !in_ready_o) |-> (out_valid_o && !out_ready_i))
    else $error("input refused without an output stall");

  // a stall freezes the inner stages
  a_stall_holds_pipe: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !out_ready_i) |=> ($stable(v4_q) && $stable(days_valid)))
    else $error("pipeline moved during a stall");

  // an overflowing day product must saturate the result
  a_saturate: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (v4_q && adv && (prod4_q[ProdW-1:EpochW] != '0)) |=> (epoch_seconds_o == EpochMax))
    else $error("overflow did not saturate");

  // hold a waiting result until the receiver takes it
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !out_ready_i) |=> (out_valid_o && $stable(epoch_seconds_o)))
    else $error("result changed while stalled");

endmodule
